[rtl/core/key_debounce_hold_timer_macros.svh]
// Assertion helpers for the key debounce block.
`ifndef KEY_DEBOUNCE_HOLD_TIMER_MACROS_SVH
`define KEY_DEBOUNCE_HOLD_TIMER_MACROS_SVH

// Check a consequence in the same cycle.
`define KDH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define KDH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/kdh_pkg.sv]
package kdh_pkg;

  localparam int NUM_KEYS = 8;
  localparam int KEY_W    = 3;
  localparam int CNT_W    = 8;
  localparam int HOLD_W   = 17;
  localparam int DUR_W    = 25;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 8;
  localparam int CIDX_W   = 2;

  localparam logic [HOLD_W-1:0] HOLD_LIMIT = 17'd100000;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd3;
  localparam logic [CFG_W-1:0] PERIOD_RST   = 8'd50;
  localparam logic [CFG_W-1:0] ENABLE_RST   = 8'd0;

  // Event codes
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] EV_HOLD    = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_PERIOD   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ENABLE   = 2'd2;

  typedef struct packed {
    logic              pressed;
    logic [CNT_W-1:0]  cnt;
    logic [HOLD_W-1:0] hold;
  } key_state_t;

  typedef struct packed {
    key_state_t        nxt;
    logic              ev_valid;
    logic [KIND_W-1:0] kind;
    logic [DUR_W-1:0]  dur;
  } key_result_t;

  // One more equal sample reaches the debounce count.
  function automatic logic count_reached(input logic [CNT_W-1:0] cnt,
                                         input logic [CFG_W-1:0] dcount);
    logic [CNT_W:0] c;
    c = {1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1};
    return c >= {1'b0, dcount};
  endfunction

endpackage

[rtl/core/kdh_key_unit.sv]
module kdh_key_unit
  import kdh_pkg::*;
(
  input  key_state_t       cur,
  input  logic             level,
  input  logic [CFG_W-1:0] debounce_count,
  input  logic [CFG_W-1:0] scan_period_ms,
  output key_result_t      res
);

  logic [CNT_W-1:0]  c_inc;
  logic              reached;
  logic [HOLD_W:0]   t_inc;
  logic [HOLD_W-1:0] t_sat;
  logic [DUR_W-1:0]  product;

  // Shared counter step, saturating hold count and the one multiplier
  always_comb begin
    c_inc   = cur.cnt + {{(CNT_W-1){1'b0}}, 1'b1};
    reached = count_reached(cur.cnt, debounce_count);
    t_inc   = {1'b0, cur.hold} + {{HOLD_W{1'b0}}, 1'b1};
    t_sat   = (t_inc >= {1'b0, HOLD_LIMIT}) ? HOLD_LIMIT : t_inc[HOLD_W-1:0];
    product = DUR_W'(t_sat) * DUR_W'(scan_period_ms);
  end

  // Two-state debouncer for the selected key
  always_comb begin
    res          = '0;
    res.nxt      = cur;
    res.ev_valid = 1'b0;
    res.kind     = EV_HOLD;
    res.dur      = '0;
    if (!cur.pressed) begin
      if (level) begin
        if (reached) begin
          res.nxt.cnt     = '0;
          res.nxt.pressed = 1'b1;
          res.ev_valid    = 1'b1;
          res.kind        = EV_PRESS;
        end else begin
          res.nxt.cnt = c_inc;
        end
      end else begin
        res.nxt.cnt = '0;
      end
    end else begin
      res.ev_valid = 1'b1;
      res.dur      = product;
      res.nxt.hold = t_sat;
      if (!level && reached) begin
        res.kind        = EV_RELEASE;
        res.nxt.cnt     = '0;
        res.nxt.hold    = '0;
        res.nxt.pressed = 1'b0;
      end else if (!level) begin
        res.nxt.cnt = c_inc;
      end else begin
        res.nxt.cnt = '0;
      end
    end
  end

endmodule

[rtl/core/key_debounce_hold_timer.sv]
// Operation: a scan tick is accepted in idle, then keys 0 to 7 are visited one per cycle
// unless the output register is stalled; the event of key k is loaded into the output register
// while key k is visited. A new scan tick is accepted only in idle, after key 7 is done;
// the single key datapath and multiplier set this.
// Reset: debounce count 3, scan period 50 ms, no key enabled, all keys released, output empty.
`include "key_debounce_hold_timer_macros.svh"

module key_debounce_hold_timer
  import kdh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NUM_KEYS-1:0] in_key_levels,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KEY_W-1:0]    out_key_index,
  output logic [KIND_W-1:0]   out_event_kind,
  output logic [DUR_W-1:0]    out_duration_ms,
  output logic                out_last_event,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_r, state_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [NUM_KEYS-1:0] levels_r;
  logic [CFG_W-1:0]    debounce_r;
  logic [CFG_W-1:0]    period_r;
  logic [CFG_W-1:0]    enable_r;
  key_state_t          st_r [NUM_KEYS];

  logic                out_valid_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [DUR_W-1:0]    out_dur_r;
  logic                out_last_r;

  key_state_t          cur;
  key_result_t         res;
  logic                key_en;
  logic                ev;
  logic                out_free;
  logic                step_ok;
  logic                last_key;
  logic [NUM_KEYS-1:0] will_emit;
  logic                later_ev;
  logic                load_out;

  assign cur      = st_r[key_r];
  assign key_en   = enable_r[key_r];
  assign in_ready = (state_r == ST_IDLE);

  kdh_key_unit u_key (
    .cur            (cur),
    .level          (levels_r[key_r]),
    .debounce_count (debounce_r),
    .scan_period_ms (period_r),
    .res            (res)
  );

  // Look ahead: does any later key give an event this tick
  always_comb begin
    for (int j = 0; j < NUM_KEYS; j++) begin
      will_emit[j] = enable_r[j] & (KEY_W'(j) > key_r) &
                     (st_r[j].pressed |
                      (levels_r[j] & count_reached(st_r[j].cnt, debounce_r)));
    end
    later_ev = |will_emit;
  end

  // Sequencer: one key per cycle, stall while the current key's event finds the output register full
  always_comb begin
    ev        = (state_r == ST_SCAN) && key_en && res.ev_valid;
    out_free  = !out_valid_r || out_ready;
    step_ok   = !ev || out_free;
    load_out  = ev && out_free;
    last_key  = (key_r == KEY_W'(NUM_KEYS - 1));
    state_nxt = state_r;
    key_nxt   = key_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          key_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (step_ok) begin
          key_nxt = key_r + KEY_W'(1);
          if (last_key) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control, configuration and key state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      key_r      <= '0;
      debounce_r <= DEBOUNCE_RST;
      period_r   <= PERIOD_RST;
      enable_r   <= ENABLE_RST;
      for (int j = 0; j < NUM_KEYS; j++) begin
        st_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
      if ((state_r == ST_SCAN) && key_en && step_ok) begin
        st_r[key_r] <= res.nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DEBOUNCE: debounce_r <= cfg_wdata;
          REG_PERIOD:   period_r   <= cfg_wdata;
          REG_ENABLE: begin
            // Clear the state of newly enabled keys
            for (int j = 0; j < NUM_KEYS; j++) begin
              if (cfg_wdata[j] && !enable_r[j]) begin
                st_r[j] <= '0;
              end
            end
            enable_r <= cfg_wdata;
          end
          default: ;
        endcase
      end
    end
  end

  // Capture key levels of the accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      levels_r <= in_key_levels;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_key_r  <= key_r;
      out_kind_r <= res.kind;
      out_dur_r  <= res.dur;
      out_last_r <= !later_ev;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_index   = out_key_r;
  assign out_event_kind  = out_kind_r;
  assign out_duration_ms = out_dur_r;
  assign out_last_event  = out_last_r;

  `KDH_ASSERT_NEXT(a_accept_starts_scan, in_valid && in_ready, state_r == ST_SCAN && key_r == '0, "accepted tick did not start a scan at key zero")
  `KDH_ASSERT_NOW(a_press_zero_dur, out_valid_r && out_kind_r == EV_PRESS, out_dur_r == '0, "press event with nonzero duration")
  `KDH_ASSERT_NOW(a_top_key_is_last, out_valid_r && out_key_r == KEY_W'(NUM_KEYS - 1), out_last_r, "event of the top key not marked last")
  `KDH_ASSERT_NOW(a_hold_limit, state_r == ST_SCAN, cur.hold <= HOLD_LIMIT, "hold count beyond limit")

endmodule
